FILE: hw/rtl/ess_pkg.sv
// Shared types and constants for the embedding similarity search block.
`default_nettype none

package ess_pkg;

  localparam int ELEM_BITS = 16;
  localparam int PROD_BITS = 2 * ELEM_BITS;
  localparam int SUM_BITS  = 48;

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
  localparam logic signed [SUM_BITS-1:0] MINUS_ONE_Q30 = -48'sd1073741824;

  localparam logic [6:0]  CAT_COUNT_RESET = 7'd64;
  localparam logic [9:0]  VEC_LEN_RESET   = 10'd512;
  localparam logic [31:0] MARGIN_RESET    = 32'd53687091;

  localparam logic KIND_TABLE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REG_CATEGORY_COUNT = 2'd0,
    REG_VECTOR_LENGTH  = 2'd1,
    REG_MARGIN         = 2'd2
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DOT   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  // Accumulate one product into a running sum, clamping to the signed sum range.
  function automatic logic signed [SUM_BITS-1:0] sat_add(
    input logic signed [SUM_BITS-1:0]  acc,
    input logic signed [PROD_BITS-1:0] prod
  );
    logic signed [SUM_BITS:0] s;
    s = {acc[SUM_BITS-1], acc} + (SUM_BITS+1)'(prod);
    if (s[SUM_BITS] != s[SUM_BITS-1]) begin
      return s[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/embedding_similarity_select.sv
// Dot-product similarity search over a table of category vectors, with margin select.
// Element writes are accepted while the block is idle; a query transaction with query_done
// starts a search if the category count is not zero. The dot phase runs one multiply-accumulate
// a cycle over ncat * max(len,1) products and then empties its pipeline; the scan phase then
// reads each similarity back and emits the matches, at most one result a cycle.
// busy falls in the cycle that carries the last result, so the next search can follow; the receiver cannot stall.
// Reset restores the register defaults and clears control; memories are not cleared.
`default_nettype none

module embedding_similarity_select import ess_pkg::*; #(
  parameter int MAX_CATEGORIES = 64,
  parameter int MAX_LENGTH     = 512
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       kind,
  input  wire logic [5:0]                 category_index,
  input  wire logic [8:0]                 element_index,
  input  wire logic signed [ELEM_BITS-1:0] element_value,
  input  wire logic                       query_done,
  output logic                            result_valid,
  output logic [5:0]                      match_index,
  output logic signed [SUM_BITS-1:0]      similarity,
  output logic                            last_match,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [3:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int CAT_W      = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;
  localparam int NCAT_W     = $clog2(MAX_CATEGORIES + 1);
  localparam int LEN_W      = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int LEN_CNT_W  = $clog2(MAX_LENGTH + 1);
  localparam int TBL_DEPTH  = MAX_CATEGORIES * (2 ** LEN_W);

  // Configuration registers
  logic [6:0]  category_count;
  logic [9:0]  vector_length;
  logic [31:0] margin;

  logic cfg_write;
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      category_count <= CAT_COUNT_RESET;
      vector_length  <= VEC_LEN_RESET;
      margin         <= MARGIN_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_CATEGORY_COUNT: category_count <= pwdata[6:0];
        REG_VECTOR_LENGTH:  vector_length  <= pwdata[9:0];
        REG_MARGIN:         margin         <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CATEGORY_COUNT: prdata = {25'd0, category_count};
      REG_VECTOR_LENGTH:  prdata = {22'd0, vector_length};
      REG_MARGIN:         prdata = margin;
      default:            prdata = '0;
    endcase
  end

  // Saturated search sizes
  logic [NCAT_W-1:0]    ncat_cfg;
  logic [LEN_CNT_W-1:0] len_cfg;
  assign ncat_cfg = (32'(category_count) > 32'(MAX_CATEGORIES)) ?
                    NCAT_W'(MAX_CATEGORIES) : NCAT_W'(category_count);
  assign len_cfg  = (32'(vector_length) > 32'(MAX_LENGTH)) ?
                    LEN_CNT_W'(MAX_LENGTH) : LEN_CNT_W'(vector_length);

  state_t state;
  assign busy = (state != ST_IDLE);

  logic accept, pos_ok, cat_ok, tbl_we, q_we, launch;
  assign accept = start && !busy;
  assign pos_ok = 32'(element_index) < 32'(MAX_LENGTH);
  assign cat_ok = 32'(category_index) < 32'(MAX_CATEGORIES);
  assign tbl_we = accept && (kind == KIND_TABLE) && cat_ok && pos_ok;
  assign q_we   = accept && (kind == KIND_QUERY) && pos_ok;
  assign launch = accept && (kind == KIND_QUERY) && query_done && (ncat_cfg != '0);

  // Dot phase counters and pipeline tags
  logic [CAT_W-1:0]     row;
  logic [LEN_W-1:0]     col;
  logic [NCAT_W-1:0]    ncat_q;
  logic [LEN_CNT_W-1:0] len_q;
  logic                 zero_len;
  logic                 row_last, col_last;

  assign row_last = (NCAT_W'(row) == ncat_q - NCAT_W'(1));
  assign col_last = (LEN_CNT_W'(col) == len_q - LEN_CNT_W'(1));

  logic                 v1, last1, v2, last2;
  logic [CAT_W-1:0]     row1, row2;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [SUM_BITS-1:0]  acc, acc_next, best;
  logic signed [SUM_BITS:0]    threshold;

  // Memories
  logic signed [ELEM_BITS-1:0] tbl_mem [TBL_DEPTH];
  logic signed [ELEM_BITS-1:0] q_mem   [MAX_LENGTH];
  logic signed [SUM_BITS-1:0]  sim_mem [MAX_CATEGORIES];
  logic signed [ELEM_BITS-1:0] tbl_rdata, q_rdata;
  logic signed [SUM_BITS-1:0]  sim_rdata;

  logic [CAT_W+LEN_W-1:0] tbl_waddr, tbl_raddr;
  logic [CAT_W-1:0]       scan_row, s_row;
  logic                   sim_we;

  assign tbl_waddr = {CAT_W'(category_index), LEN_W'(element_index)};
  assign tbl_raddr = {row, col};
  assign acc_next  = sat_add(acc, prod);
  assign sim_we    = v2 && last2;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= element_value;
    end
    tbl_rdata <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[LEN_W'(element_index)] <= element_value;
    end
    q_rdata <= q_mem[col];
  end

  // The dot phase writes this store and the scan phase reads it; they never overlap.
  always_ff @(posedge clk) begin
    if (sim_we) begin
      sim_mem[row2] <= acc_next;
    end
    sim_rdata <= sim_mem[scan_row];
  end

  // Scan phase
  logic                      scan_issue, s_v, s_last, hit;
  logic                      pend_v;
  logic [CAT_W-1:0]          pend_row;
  logic signed [SUM_BITS-1:0] pend_sim;

  assign hit = ($signed({sim_rdata[SUM_BITS-1], sim_rdata}) >= threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      v1           <= 1'b0;
      v2           <= 1'b0;
      s_v          <= 1'b0;
      scan_issue   <= 1'b0;
      pend_v       <= 1'b0;
      result_valid <= 1'b0;
      best         <= MINUS_ONE_Q30;
    end else begin
      result_valid <= 1'b0;
      v1    <= (state == ST_DOT);
      last1 <= col_last;
      row1  <= row;
      v2    <= v1;
      last2 <= last1;
      row2  <= row1;
      if (v1) begin
        prod <= zero_len ? '0 : PROD_BITS'(tbl_rdata) * PROD_BITS'(q_rdata);
      end
      if (v2) begin
        if (last2) begin
          acc <= '0;
          if (acc_next > best) begin
            best <= acc_next;
          end
        end else begin
          acc <= acc_next;
        end
      end

      s_v    <= scan_issue;
      s_last <= row_last;
      s_row  <= scan_row;

      case (state)
        ST_IDLE: begin
          if (launch) begin
            state    <= ST_DOT;
            ncat_q   <= ncat_cfg;
            zero_len <= (len_cfg == '0);
            len_q    <= (len_cfg == '0) ? LEN_CNT_W'(1) : len_cfg;
            row      <= '0;
            col      <= '0;
            acc      <= '0;
            best     <= MINUS_ONE_Q30;
          end
        end
        ST_DOT: begin
          if (col_last) begin
            col <= '0;
            if (row_last) begin
              state <= ST_DRAIN;
            end else begin
              row <= row + CAT_W'(1);
            end
          end else begin
            col <= col + LEN_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2) begin
            threshold  <= {best[SUM_BITS-1], best} - (SUM_BITS+1)'(margin);
            state      <= ST_SCAN;
            scan_issue <= 1'b1;
            scan_row   <= '0;
            row        <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            if (row_last) begin
              scan_issue <= 1'b0;
            end else begin
              scan_row <= scan_row + CAT_W'(1);
              row      <= row + CAT_W'(1);
            end
          end
          if (s_v) begin
            // A match is held back until the next match or the end of the scan, so the final one can carry last_match.
            if (hit) begin
              if (pend_v) begin
                result_valid <= 1'b1;
                match_index  <= 6'(pend_row);
                similarity   <= pend_sim;
                last_match   <= 1'b0;
              end
              pend_v   <= 1'b1;
              pend_row <= s_row;
              pend_sim <= sim_rdata;
            end
            if (s_last) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (pend_v) begin
            result_valid <= 1'b1;
            match_index  <= 6'(pend_row);
            similarity   <= pend_sim;
            last_match   <= 1'b1;
          end
          pend_v <= 1'b0;
          state  <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_match |=> !result_valid)
    else $error("result transaction followed a final match");

  a_sim_write_phase: assert property (@(posedge clk) disable iff (rst)
    sim_we |-> (state == ST_DOT || state == ST_DRAIN))
    else $error("similarity store written outside the dot phase");

  a_result_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == ST_SCAN || $past(state) == ST_FLUSH))
    else $error("result transaction outside the scan phase");

  a_search_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && kind == KIND_QUERY && query_done))
    else $error("search started without a final query element");

endmodule

`default_nettype wire

FILE: sim/ess_checker.sv
// Checker for the similarity search block: mirrors its state, predicts matches, compares them.
module ess_checker import ess_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       kind,
  input  logic [5:0]                 category_index,
  input  logic [8:0]                 element_index,
  input  logic signed [ELEM_BITS-1:0] element_value,
  input  logic                       query_done,
  input  logic                       result_valid,
  input  logic [5:0]                 match_index,
  input  logic signed [SUM_BITS-1:0] similarity,
  input  logic                       last_match,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output int                         mismatch_count,
  output int                         outstanding
);

  localparam int NUM_ROWS = 64;
  localparam int ROW_LEN  = 512;
  localparam longint SCORE_HI = (64'sd1 <<< (SUM_BITS - 1)) - 64'sd1;
  localparam longint SCORE_LO = -(64'sd1 <<< (SUM_BITS - 1));
  localparam longint START_BEST = -(64'sd1 <<< 30);

  typedef struct {
    logic [5:0]                 idx;
    logic signed [SUM_BITS-1:0] score;
    logic                       last;
  } match_t;

  logic signed [ELEM_BITS-1:0] cat_vectors [NUM_ROWS][ROW_LEN];
  logic signed [ELEM_BITS-1:0] query_elems [ROW_LEN];
  logic [6:0]  cfg_count;
  logic [9:0]  cfg_len;
  logic [31:0] cfg_margin;
  match_t      expected_matches [$];
  match_t      head;

  initial begin
    mismatch_count = 0;
    outstanding = 0;
  end

  function automatic longint clamp_sum(input longint acc, input longint prod);
    longint s;
    s = acc + prod;
    if (s > SCORE_HI) return SCORE_HI;
    if (s < SCORE_LO) return SCORE_LO;
    return s;
  endfunction

  // Runs one search over the categories in use and queues the categories that pass.
  task automatic score_query();
    longint scores [NUM_ROWS];
    longint best;
    longint floor_score;
    longint acc;
    int     ncat;
    int     len;
    int     c;
    int     e;
    int     final_cat;
    match_t m;
    ncat = (cfg_count > NUM_ROWS) ? NUM_ROWS : int'(cfg_count);
    len  = (cfg_len > ROW_LEN) ? ROW_LEN : int'(cfg_len);
    best = START_BEST;
    for (c = 0; c < ncat; c++) begin
      acc = 0;
      for (e = 0; e < len; e++) begin
        acc = clamp_sum(acc, longint'(cat_vectors[c][e]) * longint'(query_elems[e]));
      end
      scores[c] = acc;
      if (acc > best) best = acc;
    end
    floor_score = best - longint'({32'd0, cfg_margin});
    final_cat = -1;
    for (c = 0; c < ncat; c++) begin
      if (scores[c] >= floor_score) final_cat = c;
    end
    for (c = 0; c < ncat; c++) begin
      if (scores[c] >= floor_score) begin
        m.idx   = 6'(c);
        m.score = scores[c][SUM_BITS-1:0];
        m.last  = (c == final_cat);
        expected_matches = {expected_matches, m};
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_count  = CAT_COUNT_RESET;
      cfg_len    = VEC_LEN_RESET;
      cfg_margin = MARGIN_RESET;
      expected_matches.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_CATEGORY_COUNT: cfg_count = pwdata[6:0];
          REG_VECTOR_LENGTH:  cfg_len = pwdata[9:0];
          REG_MARGIN:         cfg_margin = pwdata;
          default: ;
        endcase
      end

      if (result_valid) begin
        if (expected_matches.size() == 0) begin
          $error("match_index: unexpected result, got %0d", match_index);
          mismatch_count++;
        end else begin
          head = expected_matches.pop_front();
          if (match_index !== head.idx) begin
            $error("match_index: expected %0d, got %0d", head.idx, match_index);
            mismatch_count++;
          end
          if (similarity !== head.score) begin
            $error("similarity: expected %0d, got %0d", head.score, similarity);
            mismatch_count++;
          end
          if (last_match !== head.last) begin
            $error("last_match: expected %0d, got %0d", head.last, last_match);
            mismatch_count++;
          end
        end
      end

      if (start && !busy) begin
        if (kind == KIND_TABLE) begin
          cat_vectors[category_index][element_index] = element_value;
        end else begin
          query_elems[element_index] = element_value;
          if (query_done) score_query();
        end
      end
    end
    outstanding = expected_matches.size();
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the similarity search block: stimulus, register setup and verdict.
module tb_top;
  import ess_pkg::*;

  localparam logic [3:0] UNUSED_ADDR = 4'd12;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       kind = KIND_TABLE;
  logic [5:0]                 category_index = '0;
  logic [8:0]                 element_index = '0;
  logic signed [ELEM_BITS-1:0] element_value = '0;
  logic                       query_done = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [3:0]                 paddr = '0;
  logic [31:0]                pwdata = '0;

  logic                       busy;
  logic                       result_valid;
  logic [5:0]                 match_index;
  logic signed [SUM_BITS-1:0] similarity;
  logic                       last_match;
  logic [31:0]                prdata;
  logic                       pready;

  int mismatch_count;
  int outstanding;

  // Which table and query entries hold a value, so a search never reads an unwritten one.
  bit tab_set [64][512];
  bit qry_set [512];
  int eff_count = 64;
  int eff_len = 512;
  bit no_gaps = 1'b0;
  int items_sent = 0;

  always #10 clk = ~clk;

  embedding_similarity_select i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .category_index (category_index),
    .element_index  (element_index),
    .element_value  (element_value),
    .query_done     (query_done),
    .result_valid   (result_valid),
    .match_index    (match_index),
    .similarity     (similarity),
    .last_match     (last_match),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  ess_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .category_index (category_index),
    .element_index  (element_index),
    .element_value  (element_value),
    .query_done     (query_done),
    .result_valid   (result_valid),
    .match_index    (match_index),
    .similarity     (similarity),
    .last_match     (last_match),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [ELEM_BITS-1:0] random_element();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return ELEM_BITS'($urandom);
    if (r < 6) begin
      case ($urandom_range(0, 3))
        0: return 16'sh8000;
        1: return 16'sh7FFF;
        2: return '0;
        default: return '1;
      endcase
    end
    return ELEM_BITS'($urandom_range(0, 16)) - 16'sd8;
  endfunction

  // Presents one transaction and returns at the edge that accepts it.
  task automatic issue_element(input logic k, input logic [5:0] cat, input logic [8:0] pos,
                               input logic signed [ELEM_BITS-1:0] val, input logic done);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    kind           <= k;
    category_index <= cat;
    element_index  <= pos;
    element_value  <= val;
    query_done     <= done;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    if (k == KIND_TABLE) tab_set[cat][pos] = 1'b1;
    else qry_set[pos] = 1'b1;
    items_sent++;
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_registers(input logic [31:0] cnt, input logic [31:0] len,
                               input logic [31:0] margin);
    write_reg({REG_CATEGORY_COUNT, 2'b00}, cnt);
    write_reg({REG_VECTOR_LENGTH, 2'b00}, len);
    write_reg({REG_MARGIN, 2'b00}, margin);
    eff_count = (cnt[6:0] > 7'd64) ? 64 : int'(cnt[6:0]);
    eff_len   = (len[9:0] > 10'd512) ? 512 : int'(len[9:0]);
    no_gaps   = ($urandom_range(0, 3) == 0);
  endtask

  // Waits for all matches and for the block to go idle, then lets a search's length pass.
  task automatic drain_block();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (eff_count * (eff_len > 0 ? eff_len : 1) + eff_count + 8) @(posedge clk);
  endtask

  task automatic fill_unwritten();
    int r;
    int e;
    for (r = 0; r < eff_count; r++) begin
      for (e = 0; e < eff_len; e++) begin
        if (!tab_set[r][e]) begin
          issue_element(KIND_TABLE, 6'(r), 9'(e), random_element(), 1'($urandom));
        end
      end
    end
    for (e = 0; e < eff_len; e++) begin
      if (!qry_set[e]) issue_element(KIND_QUERY, 6'($urandom), 9'(e), random_element(), 1'b0);
    end
  endtask

  task automatic random_registers();
    int cnt;
    int len;
    logic [31:0] margin;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        cnt = $urandom_range(1, 8);
        len = $urandom_range(1, 8);
      end
      6, 7: begin
        cnt = $urandom_range(9, 127);
        len = $urandom_range(0, 3);
      end
      8: begin
        cnt = $urandom_range(1, 4);
        len = $urandom_range(9, 40);
      end
      default: begin
        cnt = $urandom_range(0, 3);
        len = $urandom_range(0, 8);
      end
    endcase
    case ($urandom_range(0, 4))
      0: margin = 32'd0;
      1: margin = MARGIN_RESET;
      2: margin = $urandom_range(0, 1 << 28);
      3: margin = $urandom;
      default: margin = 32'h8000_0000;
    endcase
    // Bits above each register's width are ignored by the block.
    set_registers({($urandom_range(0, 1) ? 25'($urandom) : 25'd0), 7'(cnt)},
                  {($urandom_range(0, 1) ? 22'($urandom) : 22'd0), 10'(len)}, margin);
  endtask

  task automatic random_transaction();
    int r;
    logic [5:0] row;
    logic [8:0] pos;
    r   = $urandom_range(0, 99);
    row = (eff_count > 0) ? 6'($urandom_range(0, eff_count - 1)) : 6'($urandom);
    pos = (eff_len > 0) ? 9'($urandom_range(0, eff_len - 1)) : 9'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      row = 6'($urandom);
      pos = 9'($urandom);
    end
    if (r < 40) issue_element(KIND_TABLE, row, pos, random_element(), 1'($urandom));
    else if (r < 75) issue_element(KIND_QUERY, 6'($urandom), pos, random_element(), 1'b0);
    else issue_element(KIND_QUERY, 6'($urandom), pos, random_element(), 1'b1);
  endtask

  initial begin
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Opposing extremes push every similarity below -1.0, so nothing passes a zero margin.
    set_registers(32'd2, 32'd2, 32'd0);
    issue_element(KIND_TABLE, 6'd0, 9'd0, 16'sh7FFF, 1'b0);
    issue_element(KIND_TABLE, 6'd0, 9'd1, 16'sh7FFF, 1'b0);
    issue_element(KIND_TABLE, 6'd1, 9'd0, 16'sh7FFF, 1'b0);
    issue_element(KIND_TABLE, 6'd1, 9'd1, 16'sh7FFF, 1'b1);
    issue_element(KIND_QUERY, 6'd63, 9'd0, 16'sh8000, 1'b0);
    issue_element(KIND_QUERY, 6'd0, 9'd1, 16'sh8000, 1'b1);
    // Equal similarities just below zero: both categories tie for best.
    issue_element(KIND_QUERY, 6'd17, 9'd0, 16'sh7FFF, 1'b1);
    // The most negative element squared gives the largest product.
    issue_element(KIND_TABLE, 6'd0, 9'd0, 16'sh8000, 1'b0);
    issue_element(KIND_TABLE, 6'd0, 9'd1, 16'sh8000, 1'b0);
    issue_element(KIND_QUERY, 6'd0, 9'd0, 16'sh8000, 1'b1);

    // Count above its limit saturates; a wide margin lets every category through.
    drain_block();
    set_registers(32'd127, 32'd1, 32'h8000_0000);
    fill_unwritten();
    issue_element(KIND_QUERY, 6'd5, 9'd0, random_element(), 1'b1);

    // No categories in use: the search emits nothing.
    drain_block();
    set_registers(32'd0, 32'd5, MARGIN_RESET);
    issue_element(KIND_QUERY, 6'd0, 9'd3, random_element(), 1'b1);

    // Zero length makes every similarity zero.
    drain_block();
    set_registers(32'd3, 32'd0, 32'd0);
    issue_element(KIND_TABLE, 6'd63, 9'd511, random_element(), 1'b1);
    issue_element(KIND_QUERY, 6'd0, 9'd511, random_element(), 1'b1);

    // The largest margin the register holds.
    drain_block();
    set_registers(32'd2, 32'd2, 32'hFFFF_FFFF);
    fill_unwritten();
    issue_element(KIND_QUERY, 6'd0, 9'd0, random_element(), 1'b1);

    // A write past the last register changes nothing.
    drain_block();
    set_registers(32'd2, 32'd2, 32'd0);
    write_reg(UNUSED_ADDR, $urandom);
    issue_element(KIND_QUERY, 6'd0, 9'd1, random_element(), 1'b1);

    drain_block();
    set_registers(32'd64, 32'd1, MARGIN_RESET);
    fill_unwritten();
    issue_element(KIND_QUERY, 6'd0, 9'd0, random_element(), 1'b1);

    while (items_sent < 280) begin
      drain_block();
      random_registers();
      fill_unwritten();
      n = $urandom_range(15, 40);
      repeat (n) begin
        random_transaction();
      end
    end

    drain_block();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
